FILE: rtl/core/mips_branch_jump_resolver_assert.svh
// ---------------------------------------------------------------------------
// mips_branch_jump_resolver_assert.svh
// Assertion macros for the branch/jump resolver.
// ---------------------------------------------------------------------------
`ifndef MIPS_BRANCH_JUMP_RESOLVER_ASSERT_SVH
`define MIPS_BRANCH_JUMP_RESOLVER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define MBJR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbjr assertion failed");

// next-cycle implication, checked out of reset
`define MBJR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbjr assertion failed");

`else

`define MBJR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MBJR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/mbjr_pkg.sv
// ---------------------------------------------------------------------------
// mbjr_pkg
// Opcodes, field codes and result type for the branch/jump resolver.
// ---------------------------------------------------------------------------
package mbjr_pkg;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_BEQL    = 6'd20;
  localparam logic [5:0] OP_BNEL    = 6'd21;
  localparam logic [5:0] OP_BLEZL   = 6'd22;
  localparam logic [5:0] OP_BGTZL   = 6'd23;

  // SPECIAL funct codes
  localparam logic [5:0] FN_JR   = 6'd8;
  localparam logic [5:0] FN_JALR = 6'd9;

  // REGIMM rt codes
  localparam logic [4:0] RI_BLTZ    = 5'd0;
  localparam logic [4:0] RI_BGEZ    = 5'd1;
  localparam logic [4:0] RI_BLTZL   = 5'd2;
  localparam logic [4:0] RI_BGEZL   = 5'd3;
  localparam logic [4:0] RI_BLTZAL  = 5'd16;
  localparam logic [4:0] RI_BGEZAL  = 5'd17;
  localparam logic [4:0] RI_BLTZALL = 5'd18;
  localparam logic [4:0] RI_BGEZALL = 5'd19;

  // REGIMM rt bit meanings
  localparam int unsigned RI_LIKELY_BIT = 1;
  localparam int unsigned RI_LINK_BIT   = 4;

  localparam logic [4:0]  RA_REG      = 5'd31;
  localparam logic [31:0] REGION_MASK = 32'hF000_0000;
  localparam logic [31:0] LINK_OFFSET = 32'd4;

  typedef struct packed {
    logic        recognized;
    logic        taken;
    logic [31:0] next_pc;
    logic        link_write;
    logic [4:0]  link_reg;
    logic [31:0] link_value;
    logic        nullify_delay;
  } mbjr_result_t;

endpackage

FILE: rtl/core/mbjr_decode.sv
// ---------------------------------------------------------------------------
// mbjr_decode
// Combinational decode, compare and target generation for one item.
// ---------------------------------------------------------------------------
module mbjr_decode
  import mbjr_pkg::*;
(
  input  logic [31:0]        instruction_i,
  input  logic [31:0]        slot_address_i,
  input  logic signed [31:0] rs_value_i,
  input  logic signed [31:0] rt_value_i,
  output mbjr_result_t       result_o
);

  logic [5:0]  op;
  logic [4:0]  rtf;
  logic [4:0]  rdf;
  logic [5:0]  fn;
  logic [31:0] btarget;
  logic [31:0] jtarget;
  logic [31:0] ret_addr;
  logic        a_neg;
  logic        a_zero;
  logic        a_eq_b;
  logic        known;
  logic        take;
  logic        likely;
  logic        link;
  logic [31:0] target;
  logic [4:0]  lreg;

  assign op  = instruction_i[31:26];
  assign rtf = instruction_i[20:16];
  assign rdf = instruction_i[15:11];
  assign fn  = instruction_i[5:0];

  // slot + sext(imm) << 2, wraps mod 2^32
  assign btarget  = slot_address_i + {{14{instruction_i[15]}}, instruction_i[15:0], 2'b00};
  assign jtarget  = (slot_address_i & REGION_MASK) | {4'b0000, instruction_i[25:0], 2'b00};
  assign ret_addr = slot_address_i + LINK_OFFSET;

  assign a_neg  = rs_value_i[31];
  assign a_zero = (rs_value_i == 32'sd0);
  assign a_eq_b = (rs_value_i == rt_value_i);

  always_comb begin
    known  = 1'b1;
    take   = 1'b0;
    likely = 1'b0;
    link   = 1'b0;
    target = btarget;
    lreg   = RA_REG;
    case (op)
      OP_SPECIAL: begin
        case (fn)
          FN_JR: begin
            take   = 1'b1;
            target = rs_value_i;
          end
          FN_JALR: begin
            take   = 1'b1;
            target = rs_value_i;
            link   = 1'b1;
            lreg   = rdf;
          end
          default: known = 1'b0;
        endcase
      end
      OP_REGIMM: begin
        case (rtf)
          RI_BLTZ, RI_BLTZL, RI_BLTZAL, RI_BLTZALL: take = a_neg;
          RI_BGEZ, RI_BGEZL, RI_BGEZAL, RI_BGEZALL: take = !a_neg;
          default: known = 1'b0;
        endcase
        likely = rtf[RI_LIKELY_BIT];
        // link follows the branch decision, likely forms too
        link   = rtf[RI_LINK_BIT] && take;
      end
      OP_J: begin
        take   = 1'b1;
        target = jtarget;
      end
      OP_JAL: begin
        take   = 1'b1;
        target = jtarget;
        link   = 1'b1;
      end
      OP_BEQ, OP_BEQL: begin
        take   = a_eq_b;
        likely = (op == OP_BEQL);
      end
      OP_BNE, OP_BNEL: begin
        take   = !a_eq_b;
        likely = (op == OP_BNEL);
      end
      OP_BLEZ, OP_BLEZL: begin
        take   = a_neg || a_zero;
        likely = (op == OP_BLEZL);
      end
      OP_BGTZ, OP_BGTZL: begin
        take   = !a_neg && !a_zero;
        likely = (op == OP_BGTZL);
      end
      default: known = 1'b0;
    endcase
  end

  always_comb begin
    result_o = '0;
    if (known) begin
      result_o.recognized    = 1'b1;
      result_o.taken         = take;
      result_o.next_pc       = target;
      result_o.link_write    = link;
      result_o.link_reg      = link ? lreg : 5'd0;
      result_o.link_value    = link ? ret_addr : 32'd0;
      result_o.nullify_delay = likely && !take;
    end
  end

endmodule

FILE: rtl/core/mips_branch_jump_resolver.sv
// ---------------------------------------------------------------------------
// mips_branch_jump_resolver
// Resolves one MIPS jump or branch per item: decision, target, link write
// and delay-slot nullify.
// ---------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  item in  | start && !busy      | instruction_i, slot_address_i,
//           |                     | rs_value_i, rt_value_i
//  result   | done_o (one cycle)  | recognized_o, taken_o, next_pc_o,
//           |                     | link_write_o, link_reg_o, link_value_o,
//           |                     | nullify_delay_o
//
//  Throughput: one item per cycle; busy stays low.
//  Path: an accepted item is held in the input register, then passes
//  decode/compare/adder logic into the result register that drives done_o.
//  Reset clears only the two valid flags; payload registers are not reset.
//  The receiver has no back-pressure, so results are never held off.
//
`include "mips_branch_jump_resolver_assert.svh"

module mips_branch_jump_resolver
  import mbjr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        instruction_i,
  input  logic [31:0]        slot_address_i,
  input  logic signed [31:0] rs_value_i,
  input  logic signed [31:0] rt_value_i,
  output logic               done_o,
  output logic               recognized_o,
  output logic               taken_o,
  output logic [31:0]        next_pc_o,
  output logic               link_write_o,
  output logic [4:0]         link_reg_o,
  output logic [31:0]        link_value_o,
  output logic               nullify_delay_o
);

  // input stage
  logic               in_vld_q;
  logic [31:0]        instr_q;
  logic [31:0]        slot_q;
  logic signed [31:0] rs_q;
  logic signed [31:0] rt_q;

  // result stage
  logic               out_vld_q;
  mbjr_result_t       res_d;
  mbjr_result_t       res_q;

  logic               accept;

  // fully pipelined: never stalls the sender
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= accept;
      out_vld_q <= in_vld_q;
    end
  end

  // payload: capture only on accept to save toggles
  always_ff @(posedge clk_i) begin
    if (accept) begin
      instr_q <= instruction_i;
      slot_q  <= slot_address_i;
      rs_q    <= rs_value_i;
      rt_q    <= rt_value_i;
    end
  end

  mbjr_decode u_decode (
    .instruction_i  (instr_q),
    .slot_address_i (slot_q),
    .rs_value_i     (rs_q),
    .rt_value_i     (rt_q),
    .result_o       (res_d)
  );

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o          = out_vld_q;
  assign recognized_o    = res_q.recognized;
  assign taken_o         = res_q.taken;
  assign next_pc_o       = res_q.next_pc;
  assign link_write_o    = res_q.link_write;
  assign link_reg_o      = res_q.link_reg;
  assign link_value_o    = res_q.link_value;
  assign nullify_delay_o = res_q.nullify_delay;

  // every accepted item shows up on done_o after the input and result registers
  `MBJR_ASSERT_NEXT(a_accept_done, clk_i, rst_ni, accept, ##1 done_o)
  // no result without an item accepted earlier and passed through both registers
  `MBJR_ASSERT_IMPL(a_done_src, clk_i, rst_ni, done_o, $past(accept, 2))
  // unrecognized items carry an all-zero result
  `MBJR_ASSERT_IMPL(a_unknown_zero, clk_i, rst_ni, done_o && !recognized_o, !taken_o && !link_write_o && !nullify_delay_o && next_pc_o == 32'd0)
  // nullify only on a not-taken branch; link fields zero without a link write
  `MBJR_ASSERT_IMPL(a_null_link, clk_i, rst_ni, done_o, !(nullify_delay_o && taken_o) && (link_write_o || (link_reg_o == 5'd0 && link_value_o == 32'd0)))

endmodule

FILE: bench/branch_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// branch_result_checker
// Watches the item and result channels of the branch/jump resolver, predicts
// each resolution and compares it, field by field, in arrival order.
// ----------------------------------------------------------------------------
module branch_result_checker
  import mbjr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] instruction_i,
  input  logic [31:0] slot_address_i,
  input  logic [31:0] rs_value_i,
  input  logic [31:0] rt_value_i,
  input  logic        done_o,
  input  logic        recognized_o,
  input  logic        taken_o,
  input  logic [31:0] next_pc_o,
  input  logic        link_write_o,
  input  logic [4:0]  link_reg_o,
  input  logic [31:0] link_value_o,
  input  logic        nullify_delay_o,
  output int          mismatch_count_o,
  output int          pending_results_o
);

  localparam int PRINT_CAP = 50;

  mbjr_result_t predicted_results[$];

  initial begin
    mismatch_count_o  = 0;
    pending_results_o = 0;
  end

  // decision, target and link of one control transfer
  function automatic mbjr_result_t resolve_transfer(input logic [31:0] word,
                                                    input logic [31:0] slot,
                                                    input logic [31:0] rs_val,
                                                    input logic [31:0] rt_val);
    logic [5:0]   opc;
    logic [5:0]   funct;
    logic [4:0]   rt_code;
    logic [4:0]   rd_code;
    logic [31:0]  branch_pc;
    logic [31:0]  jump_pc;
    logic [31:0]  dest;
    logic [4:0]   lreg;
    logic         known;
    logic         take;
    logic         likely;
    logic         link;
    mbjr_result_t r;
    opc       = word[31:26];
    funct     = word[5:0];
    rt_code   = word[20:16];
    rd_code   = word[15:11];
    branch_pc = slot + {{14{word[15]}}, word[15:0], 2'b00};
    jump_pc   = (slot & REGION_MASK) | {4'b0000, word[25:0], 2'b00};
    known     = 1'b1;
    take      = 1'b0;
    likely    = 1'b0;
    link      = 1'b0;
    dest      = branch_pc;
    lreg      = RA_REG;
    case (opc)
      OP_SPECIAL: begin
        if (funct == FN_JR) begin
          take = 1'b1;
          dest = rs_val;
        end else if (funct == FN_JALR) begin
          take = 1'b1;
          dest = rs_val;
          link = 1'b1;
          lreg = rd_code;
        end else begin
          known = 1'b0;
        end
      end
      OP_REGIMM: begin
        case (rt_code)
          RI_BLTZ, RI_BLTZL, RI_BLTZAL, RI_BLTZALL: take = rs_val[31];
          RI_BGEZ, RI_BGEZL, RI_BGEZAL, RI_BGEZALL: take = !rs_val[31];
          default: known = 1'b0;
        endcase
        likely = rt_code[RI_LIKELY_BIT];
        // link follows the decision, likely forms included
        link   = rt_code[RI_LINK_BIT] && take;
      end
      OP_J: begin
        take = 1'b1;
        dest = jump_pc;
      end
      OP_JAL: begin
        take = 1'b1;
        dest = jump_pc;
        link = 1'b1;
      end
      OP_BEQ, OP_BEQL: begin
        take   = (rs_val == rt_val);
        likely = (opc == OP_BEQL);
      end
      OP_BNE, OP_BNEL: begin
        take   = (rs_val != rt_val);
        likely = (opc == OP_BNEL);
      end
      OP_BLEZ, OP_BLEZL: begin
        take   = rs_val[31] || (rs_val == '0);
        likely = (opc == OP_BLEZL);
      end
      OP_BGTZ, OP_BGTZL: begin
        take   = !rs_val[31] && (rs_val != '0);
        likely = (opc == OP_BGTZL);
      end
      default: known = 1'b0;
    endcase
    r = '0;
    if (known) begin
      r.recognized    = 1'b1;
      r.taken         = take;
      r.next_pc       = dest;
      r.link_write    = link;
      r.link_reg      = link ? lreg : 5'd0;
      r.link_value    = link ? slot + LINK_OFFSET : 32'd0;
      r.nullify_delay = likely && !take;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count_o < PRINT_CAP)
      $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatch_count_o = mismatch_count_o + 1;
  endtask

  always @(posedge clk_i) begin
    mbjr_result_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("done_o with no item pending", 32'd1, 32'd0);
        end else begin
          want = predicted_results.pop_front();
          if (recognized_o !== want.recognized)
            report_mismatch("recognized", 32'(recognized_o), 32'(want.recognized));
          if (taken_o !== want.taken)
            report_mismatch("taken", 32'(taken_o), 32'(want.taken));
          if (next_pc_o !== want.next_pc)
            report_mismatch("next_pc", next_pc_o, want.next_pc);
          if (link_write_o !== want.link_write)
            report_mismatch("link_write", 32'(link_write_o), 32'(want.link_write));
          if (link_reg_o !== want.link_reg)
            report_mismatch("link_reg", 32'(link_reg_o), 32'(want.link_reg));
          if (link_value_o !== want.link_value)
            report_mismatch("link_value", link_value_o, want.link_value);
          if (nullify_delay_o !== want.nullify_delay)
            report_mismatch("nullify_delay", 32'(nullify_delay_o),
                            32'(want.nullify_delay));
        end
      end
      if (start && !busy)
        predicted_results.push_back(resolve_transfer(instruction_i, slot_address_i,
                                                     rs_value_i, rt_value_i));
      pending_results_o <= predicted_results.size();
    end
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the branch/jump resolver: a directed sweep of every handled
// transfer and its corner cases, then random items, with random gaps on the
// item side. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
  import mbjr_pkg::*;

  localparam int RANDOM_ITEMS = 1950;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;       // extra drain after the last result

  // encodings outside the handled set
  localparam logic [5:0] OP_UNUSED = 6'h3F;
  localparam logic [5:0] FN_SLL    = 6'd0;
  localparam logic [4:0] RI_UNUSED = 5'd4;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] instruction_i = '0;
  logic [31:0] slot_address_i = '0;
  logic [31:0] rs_value_i = '0;
  logic [31:0] rt_value_i = '0;
  logic        done_o;
  logic        recognized_o;
  logic        taken_o;
  logic [31:0] next_pc_o;
  logic        link_write_o;
  logic [4:0]  link_reg_o;
  logic [31:0] link_value_o;
  logic        nullify_delay_o;

  int mismatch_count;
  int pending_results;
  int cycle_count = 0;
  bit gaps_on = 1'b1;   // cleared for a long back-to-back stretch

  always #2 clk_i = ~clk_i;

  mips_branch_jump_resolver dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .instruction_i   (instruction_i),
    .slot_address_i  (slot_address_i),
    .rs_value_i      (rs_value_i),
    .rt_value_i      (rt_value_i),
    .done_o          (done_o),
    .recognized_o    (recognized_o),
    .taken_o         (taken_o),
    .next_pc_o       (next_pc_o),
    .link_write_o    (link_write_o),
    .link_reg_o      (link_reg_o),
    .link_value_o    (link_value_o),
    .nullify_delay_o (nullify_delay_o)
  );

  branch_result_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .instruction_i     (instruction_i),
    .slot_address_i    (slot_address_i),
    .rs_value_i        (rs_value_i),
    .rt_value_i        (rt_value_i),
    .done_o            (done_o),
    .recognized_o      (recognized_o),
    .taken_o           (taken_o),
    .next_pc_o         (next_pc_o),
    .link_write_o      (link_write_o),
    .link_reg_o        (link_reg_o),
    .link_value_o      (link_value_o),
    .nullify_delay_o   (nullify_delay_o),
    .mismatch_count_o  (mismatch_count),
    .pending_results_o (pending_results)
  );

  // watchdog: a hung handshake ends the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Present one item and hold it until an edge sees start high and busy low.
  // Called right after a rising edge; start is set high on every call, even
  // when already high; it is never lowered and raised in the same step.
  task automatic send_item(input logic [31:0] word, input logic [31:0] slot,
                           input logic [31:0] rs_val, input logic [31:0] rt_val);
    start          <= 1'b1;
    instruction_i  <= word;
    slot_address_i <= slot;
    rs_value_i     <= rs_val;
    rt_value_i     <= rt_val;
    do @(posedge clk_i); while (busy);
  endtask

  // while gaps are on, about 9 items in 100 are followed by an idle gap
  task automatic maybe_idle();
    int gap;
    if (gaps_on && $urandom_range(0, 99) < 9) begin
      gap   = $urandom_range(1, 2);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // register value biased toward the sign and zero boundaries
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = 32'h0000_0000;
      1:       v = 32'h8000_0000;
      2:       v = 32'h7FFF_FFFF;
      3:       v = 32'hFFFF_FFFF;
      4:       v = $urandom_range(0, 3);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // mostly handled transfers with random fields, some raw noise words
  function automatic logic [31:0] pick_instruction();
    logic [31:0] w;
    int          sel;
    w = $urandom;
    if ($urandom_range(0, 99) < 8)
      return w;
    sel = $urandom_range(0, 19);
    case (sel)
      0:  begin w[31:26] = OP_SPECIAL; w[5:0] = FN_JR;   end
      1:  begin w[31:26] = OP_SPECIAL; w[5:0] = FN_JALR; end
      2:  begin w[31:26] = OP_REGIMM;  w[20:16] = RI_BLTZ;    end
      3:  begin w[31:26] = OP_REGIMM;  w[20:16] = RI_BGEZ;    end
      4:  begin w[31:26] = OP_REGIMM;  w[20:16] = RI_BLTZL;   end
      5:  begin w[31:26] = OP_REGIMM;  w[20:16] = RI_BGEZL;   end
      6:  begin w[31:26] = OP_REGIMM;  w[20:16] = RI_BLTZAL;  end
      7:  begin w[31:26] = OP_REGIMM;  w[20:16] = RI_BGEZAL;  end
      8:  begin w[31:26] = OP_REGIMM;  w[20:16] = RI_BLTZALL; end
      9:  begin w[31:26] = OP_REGIMM;  w[20:16] = RI_BGEZALL; end
      10: w[31:26] = OP_J;
      11: w[31:26] = OP_JAL;
      12: w[31:26] = OP_BEQ;
      13: w[31:26] = OP_BNE;
      14: w[31:26] = OP_BLEZ;
      15: w[31:26] = OP_BGTZ;
      16: w[31:26] = OP_BEQL;
      17: w[31:26] = OP_BNEL;
      18: w[31:26] = OP_BLEZL;
      default: w[31:26] = OP_BGTZL;
    endcase
    return w;
  endfunction

  initial begin
    logic [31:0] word;
    logic [31:0] slot;
    logic [31:0] rs_val;
    logic [31:0] rt_val;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed sweep ---
    // jumps: region bits from the slot, link wrap past the top of memory
    send_item({OP_J, 26'h3FF_FFFF}, 32'hA000_0004, 32'h0, 32'h0);
    send_item({OP_JAL, 26'h000_0001}, 32'hFFFF_FFFC, 32'h0, 32'h0);
    // register jumps with nonzero reserved fields; JALR to r0 still links
    send_item({OP_SPECIAL, 5'd4, 5'd31, 5'd31, 5'd31, FN_JR},
              32'h0000_1000, 32'hDEAD_BEEF, 32'h1);
    maybe_idle();
    send_item({OP_SPECIAL, 5'd2, 5'd0, 5'd0, 5'd0, FN_JALR},
              32'h0040_0008, 32'h8000_0000, 32'h0);
    send_item({OP_SPECIAL, 5'd2, 5'd0, 5'd5, 5'd0, FN_JALR},
              32'h0040_0008, 32'h7FFF_FFFC, 32'h0);
    // compare branches; most negative offset wraps below zero, largest
    // positive wraps above the top
    send_item({OP_BEQ, 5'd1, 5'd2, 16'h8000}, 32'h0000_0010, 32'h8000_0000, 32'h8000_0000);
    send_item({OP_BEQ, 5'd1, 5'd2, 16'h7FFF}, 32'hFFFF_FFF0, 32'h0, 32'hFFFF_FFFF);
    send_item({OP_BNE, 5'd1, 5'd2, 16'hFFFF}, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0);
    send_item({OP_BLEZ, 5'd3, 5'd9, 16'h0004}, 32'h1234_5678, 32'h0, 32'h5);
    send_item({OP_BGTZ, 5'd3, 5'd0, 16'h0001}, 32'h1234_5678, 32'h7FFF_FFFF, 32'h0);
    // likely forms falling through nullify the slot
    send_item({OP_BEQL, 5'd1, 5'd2, 16'h0010}, 32'h0000_2000, 32'h1, 32'h2);
    send_item({OP_BNEL, 5'd1, 5'd2, 16'h0010}, 32'h0000_2000, 32'h7, 32'h7);
    maybe_idle();
    send_item({OP_BLEZL, 5'd1, 5'd0, 16'hFFF0}, 32'h0000_2000, 32'h1, 32'h0);
    send_item({OP_BGTZL, 5'd1, 5'd0, 16'hFFF0}, 32'h0000_2000, 32'h8000_0000, 32'h0);
    // sign-test branches, linking only when taken
    send_item({OP_REGIMM, 5'd5, RI_BLTZ, 16'h0020}, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
    send_item({OP_REGIMM, 5'd5, RI_BGEZ, 16'h0020}, 32'h8000_0000, 32'h8000_0000, 32'h0);
    send_item({OP_REGIMM, 5'd5, RI_BLTZL, 16'h0020}, 32'h8000_0000, 32'h0, 32'h0);
    send_item({OP_REGIMM, 5'd5, RI_BGEZL, 16'h0020}, 32'h8000_0000, 32'h0, 32'h0);
    send_item({OP_REGIMM, 5'd5, RI_BLTZAL, 16'hFFFE}, 32'h0000_0100, 32'h1, 32'h0);
    send_item({OP_REGIMM, 5'd5, RI_BGEZAL, 16'hFFFE}, 32'h0000_0100, 32'h1, 32'h0);
    send_item({OP_REGIMM, 5'd5, RI_BLTZALL, 16'h0003}, 32'hFFFF_FFFC, 32'h8000_0000, 32'h0);
    send_item({OP_REGIMM, 5'd5, RI_BGEZALL, 16'h0003}, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'h0);
    // not handled: every result field reads zero
    send_item({OP_REGIMM, 5'd5, RI_UNUSED, 16'h0003}, 32'h0000_0100, 32'h8000_0000, 32'h0);
    send_item({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, FN_SLL}, 32'h0000_0100, 32'h1, 32'h2);
    send_item({OP_UNUSED, 26'h3FF_FFFF}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // --- random items ---
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      gaps_on = !(n >= 800 && n < 1200);   // back-to-back stretch
      word   = pick_instruction();
      slot   = ($urandom_range(0, 15) == 0) ? 32'hFFFF_FFFC : $urandom;
      rs_val = pick_operand();
      rt_val = ($urandom_range(0, 3) == 0) ? rs_val : pick_operand();
      send_item(word, slot, rs_val, rt_val);
      maybe_idle();
    end
    start <= 1'b0;

    // drain; the watchdog bounds this wait
    while (pending_results != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

FILE: mips_branch_jump_resolver.f
+incdir+rtl/core
rtl/core/mbjr_pkg.sv
rtl/core/mbjr_decode.sv
rtl/core/mips_branch_jump_resolver.sv
bench/branch_result_checker.sv
bench/tb.sv
